// File: design/uvst_pkg.sv
// shared types, constants and arithmetic helpers of the uv sphere tessellator
package uvst_pkg;

    localparam int MAX_SEGMENTS  = 256;
    localparam int MIN_SEGMENTS  = 3;
    localparam int SEG_W         = $clog2(MAX_SEGMENTS + 1);
    localparam int RAD_W         = 16;
    localparam int CFG_W         = 16;
    localparam int IDX_W         = 17;
    localparam int POS_W         = 17;
    localparam int NORM_W        = 16;
    localparam int TEX_W         = 17;
    localparam int Q_W           = 33;
    localparam int CW            = 34;
    localparam int PROD_W        = 64;
    localparam int RPROD_W       = 50;
    localparam int TRIG_W        = 32;
    localparam int CORDIC_STEPS  = 30;
    localparam int CORDIC_STAGES = CORDIC_STEPS / 2;
    localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
    localparam int CORDIC_X0     = 652032874;
    localparam int DIV_BITS      = 4;
    localparam int DIV_STAGES    = 32 / DIV_BITS;
    localparam int PH_STAGE      = DIV_STAGES + 1;
    localparam int TRIG_STAGE    = PH_STAGE + CORDIC_LAT;
    localparam int PIPE_LAST     = TRIG_STAGE + 4;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);

    localparam logic [RAD_W-1:0] RADIUS_RESET  = 16'd256;
    localparam logic [SEG_W-1:0] SEGMENT_RESET = SEG_W'(16);

    localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_INDEX  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic {
        REG_RADIUS  = 1'b0,
        REG_SEGMENT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [SEG_W-1:0] r;
        logic [Q_W-1:0]   q;
    } div_t;

    typedef struct packed {
        logic             reject;
        logic             edge_pt;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] nxt;
        logic [SEG_W-1:0] n;
        logic [RAD_W-1:0] radius;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } meta_t;

    typedef struct packed {
        meta_t meta;
        div_t  dt;
        div_t  ds;
    } item_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    function automatic div_t div_steps(input div_t a, input logic [SEG_W-1:0] n);
        div_t b;
        logic [SEG_W:0] t;
        b = a;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            t = {b.r, 1'b0};
            if (t >= {1'b0, n})
            begin
                b.r = SEG_W'(t - {1'b0, n});
                b.q = {b.q[Q_W-2:0], 1'b1};
            end
            else
            begin
                b.r = t[SEG_W-1:0];
                b.q = {b.q[Q_W-2:0], 1'b0};
            end
        end
        return b;
    endfunction

    function automatic cordic_t cordic_iter(input cordic_t a, input logic [4:0] i);
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;
        cordic_t b;
        x  = a.x;
        y  = a.y;
        z  = a.z;
        dx = y >>> i;
        dy = x >>> i;
        at = $signed({2'b00, ATAN_TURN[i]});
        if (!z[CW-1])
        begin
            b.x = x - dx;
            b.y = y + dy;
            b.z = z - at;
        end
        else
        begin
            b.x = x + dx;
            b.y = y - dy;
            b.z = z + at;
        end
        return b;
    endfunction

    function automatic logic signed [TRIG_W-1:0] sat_q30(input logic signed [CW-1:0] v,
                                                        input logic neg);
        logic signed [CW-1:0] t;
        t = neg ? -v : v;
        if (t > 34'sd1073741824)
            return 32'sd1073741824;
        else if (t < -34'sd1073741824)
            return -32'sd1073741824;
        else
            return t[TRIG_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] round30(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = (p + 64'sd536870912) >>> 30;
        return t[Q_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] to_pos(input logic signed [RPROD_W-1:0] q);
        logic signed [RPROD_W-1:0] t;
        t = (q + 50'sd536870912) >>> 30;
        if (t > 50'sd65535)
            return 17'sd65535;
        else if (t < -50'sd65535)
            return -17'sd65535;
        else
            return t[POS_W-1:0];
    endfunction

    function automatic logic signed [NORM_W-1:0] to_norm(input logic signed [Q_W-1:0] c);
        logic signed [Q_W-1:0] t;
        t = (c + 33'sd32768) >>> 16;
        if (t > 33'sd16384)
            return 16'sd16384;
        else if (t < -33'sd16384)
            return -16'sd16384;
        else
            return t[NORM_W-1:0];
    endfunction

    function automatic logic [TEX_W-1:0] tex_of(input logic [Q_W-1:0] q);
        logic [Q_W:0] t;
        t = {1'b0, q} + 34'd32768;
        return t[Q_W-1:16];
    endfunction

endpackage

// File: design/uvst_fifo.sv
// short queue between the classifying front and the compute back
module uvst_fifo import uvst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    output logic  full,
    input  logic  pop,
    output item_t pop_data,
    output logic  valid
);

    item_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic [FIFO_PTR_W:0]   count_next;

    assign full     = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: design/uvst_front.sv
// front: configuration registers, input beat acceptance and grid point classification
module uvst_front import uvst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [SEG_W-1:0] ring,
    input  logic [SEG_W-1:0] sector,
    input  logic             q_full,
    output logic             q_push,
    output item_t            q_data
);

    logic [RAD_W-1:0] radius_reg;
    logic [SEG_W-1:0] seg_reg;
    logic [SEG_W-1:0] seg_next;
    logic [SEG_W-1:0] seg_wr;
    logic [19:0]      row_base;
    logic             ring_ge;
    logic             sector_ge;

    assign seg_wr = cfg_data[SEG_W-1:0];

    always_comb
    begin
        if (seg_wr < SEG_W'(MIN_SEGMENTS))
            seg_next = SEG_W'(MIN_SEGMENTS);
        else if (seg_wr > SEG_W'(MAX_SEGMENTS))
            seg_next = SEG_W'(MAX_SEGMENTS);
        else
            seg_next = seg_wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            seg_reg    <= SEGMENT_RESET;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == REG_RADIUS)
                radius_reg <= cfg_data[RAD_W-1:0];
            else
                seg_reg <= seg_next;
        end
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    assign ring_ge   = (ring >= seg_reg);
    assign sector_ge = (sector >= seg_reg);
    assign row_base  = 20'(ring) * 20'({1'b0, seg_reg} + 1'b1);

    // first quotient bit of i * 2^32 / n is taken here, the rest in the back
    always_comb
    begin
        q_data.meta.reject  = (ring > seg_reg) || (sector > seg_reg);
        q_data.meta.edge_pt = (ring == seg_reg) || (sector == seg_reg);
        q_data.meta.cur     = IDX_W'(row_base + 20'(sector));
        q_data.meta.nxt     = IDX_W'(row_base + 20'(sector) + 20'(seg_reg) + 20'd1);
        q_data.meta.n       = seg_reg;
        q_data.meta.radius  = radius_reg;
        q_data.meta.tex_u   = '0;
        q_data.meta.tex_v   = '0;
        q_data.dt.r         = ring_ge ? SEG_W'(ring - seg_reg) : ring;
        q_data.dt.q         = Q_W'(ring_ge);
        q_data.ds.r         = sector_ge ? SEG_W'(sector - seg_reg) : sector;
        q_data.ds.q         = Q_W'(sector_ge);
    end

endmodule

// File: design/uvst_cordic.sv
// pipelined sine and cosine of a 32-bit phase, two rotation steps per stage
module uvst_cordic import uvst_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [31:0]              phase,
    output logic signed [TRIG_W-1:0] cos_val,
    output logic signed [TRIG_W-1:0] sin_val
);

    cordic_t                  cs_reg  [0:CORDIC_STAGES];
    logic                     neg_reg [0:CORDIC_STAGES];
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic                     fold;
    logic [31:0]              folded;

    // second and third quadrant: rotate by half a turn and negate at the end
    assign fold   = phase[31] ^ phase[30];
    assign folded = fold ? {~phase[31], phase[30:0]} : phase;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_reg[0].x <= CW'(CORDIC_X0);
            cs_reg[0].y <= '0;
            cs_reg[0].z <= CW'($signed(folded));
            neg_reg[0]  <= fold;
            for (int j = 1; j <= CORDIC_STAGES; j++)
            begin
                cs_reg[j]  <= cordic_iter(cordic_iter(cs_reg[j-1], 5'(2*j-2)), 5'(2*j-1));
                neg_reg[j] <= neg_reg[j-1];
            end
            cos_reg <= sat_q30(cs_reg[CORDIC_STAGES].x, neg_reg[CORDIC_STAGES]);
            sin_reg <= sat_q30(cs_reg[CORDIC_STAGES].y, neg_reg[CORDIC_STAGES]);
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// File: design/uvst_back.sv
// back: division, trig and scaling pipeline followed by the result beat sequencer
module uvst_back import uvst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  item_t                    q_data,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               kind,
    output logic signed [POS_W-1:0]  pos_x,
    output logic signed [POS_W-1:0]  pos_y,
    output logic signed [POS_W-1:0]  pos_z,
    output logic signed [NORM_W-1:0] norm_x,
    output logic signed [NORM_W-1:0] norm_y,
    output logic signed [NORM_W-1:0] norm_z,
    output logic [TEX_W-1:0]         tex_u,
    output logic [TEX_W-1:0]         tex_v,
    output logic [IDX_W-1:0]         vertex_index,
    output logic                     last
);

    logic  v_reg    [1:PIPE_LAST];
    meta_t meta_reg [1:PIPE_LAST];
    div_t  dt_reg   [1:DIV_STAGES];
    div_t  ds_reg   [1:DIV_STAGES];
    meta_t meta_ph;
    logic  adv;
    logic  take;
    logic  step;

    logic [31:0]                ph_t_reg;
    logic [31:0]                ph_p_reg;
    logic signed [TRIG_W-1:0]   ct;
    logic signed [TRIG_W-1:0]   st;
    logic signed [TRIG_W-1:0]   cp;
    logic signed [TRIG_W-1:0]   sp;

    logic signed [PROD_W-1:0]   px_reg;
    logic signed [PROD_W-1:0]   pz_reg;
    logic signed [TRIG_W-1:0]   ct1_reg;
    logic signed [Q_W-1:0]      sx_reg;
    logic signed [Q_W-1:0]      sz_reg;
    logic signed [RPROD_W-1:0]  qy_reg;
    logic signed [TRIG_W-1:0]   ct2_reg;
    logic signed [RPROD_W-1:0]  qx_reg;
    logic signed [RPROD_W-1:0]  qz_reg;
    logic signed [POS_W-1:0]    py3_reg;
    logic signed [NORM_W-1:0]   nx3_reg;
    logic signed [NORM_W-1:0]   ny3_reg;
    logic signed [NORM_W-1:0]   nz3_reg;
    logic signed [POS_W-1:0]    px4_reg;
    logic signed [POS_W-1:0]    py4_reg;
    logic signed [POS_W-1:0]    pz4_reg;
    logic signed [NORM_W-1:0]   nx4_reg;
    logic signed [NORM_W-1:0]   ny4_reg;
    logic signed [NORM_W-1:0]   nz4_reg;
    logic signed [RAD_W:0]      rad2;
    logic signed [RAD_W:0]      rad3;

    logic                       out_valid_reg;
    kind_t                      kind_reg;
    logic signed [POS_W-1:0]    pos_x_reg;
    logic signed [POS_W-1:0]    pos_y_reg;
    logic signed [POS_W-1:0]    pos_z_reg;
    logic signed [NORM_W-1:0]   norm_x_reg;
    logic signed [NORM_W-1:0]   norm_y_reg;
    logic signed [NORM_W-1:0]   norm_z_reg;
    logic [TEX_W-1:0]           tex_u_reg;
    logic [TEX_W-1:0]           tex_v_reg;
    logic [IDX_W-1:0]           vidx_reg;
    logic                       last_reg;
    logic [2:0]                 beat_reg;
    logic [IDX_W-1:0]           cur_reg;
    logic [IDX_W-1:0]           nxt_reg;
    logic [IDX_W-1:0]           idx_sel;

    assign take  = v_reg[PIPE_LAST] && (!out_valid_reg || (out_ready && last_reg));
    assign step  = out_valid_reg && out_ready && !last_reg;
    assign adv   = !v_reg[PIPE_LAST] || take;
    assign q_pop = adv && q_valid;

    always_comb
    begin
        meta_ph       = meta_reg[DIV_STAGES];
        meta_ph.tex_u = tex_of(ds_reg[DIV_STAGES].q);
        meta_ph.tex_v = tex_of(dt_reg[DIV_STAGES].q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= PIPE_LAST; k++)
                v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[1] <= q_valid;
            for (int k = 2; k <= PIPE_LAST; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[1] <= q_data.meta;
            for (int k = 2; k <= PIPE_LAST; k++)
                meta_reg[k] <= (k == PH_STAGE) ? meta_ph : meta_reg[k-1];
            dt_reg[1] <= div_steps(q_data.dt, q_data.meta.n);
            ds_reg[1] <= div_steps(q_data.ds, q_data.meta.n);
            for (int k = 2; k <= DIV_STAGES; k++)
            begin
                dt_reg[k] <= div_steps(dt_reg[k-1], meta_reg[k-1].n);
                ds_reg[k] <= div_steps(ds_reg[k-1], meta_reg[k-1].n);
            end
            // theta uses half the turn of phi for the same index
            ph_t_reg <= dt_reg[DIV_STAGES].q[Q_W-1:1];
            ph_p_reg <= ds_reg[DIV_STAGES].q[31:0];
        end
    end

    uvst_cordic u_cordic_theta
    (
        .clk     (clk),
        .en      (adv),
        .phase   (ph_t_reg),
        .cos_val (ct),
        .sin_val (st)
    );

    uvst_cordic u_cordic_phi
    (
        .clk     (clk),
        .en      (adv),
        .phase   (ph_p_reg),
        .cos_val (cp),
        .sin_val (sp)
    );

    assign rad2 = $signed({1'b0, meta_reg[TRIG_STAGE+1].radius});
    assign rad3 = $signed({1'b0, meta_reg[TRIG_STAGE+2].radius});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg  <= st * sp;
            pz_reg  <= st * cp;
            ct1_reg <= ct;

            sx_reg  <= round30(px_reg);
            sz_reg  <= round30(pz_reg);
            qy_reg  <= rad2 * $signed({ct1_reg[TRIG_W-1], ct1_reg});
            ct2_reg <= ct1_reg;

            qx_reg  <= rad3 * sx_reg;
            qz_reg  <= rad3 * sz_reg;
            py3_reg <= to_pos(qy_reg);
            nx3_reg <= to_norm(sx_reg);
            ny3_reg <= to_norm($signed({ct2_reg[TRIG_W-1], ct2_reg}));
            nz3_reg <= to_norm(sz_reg);

            px4_reg <= to_pos(qx_reg);
            pz4_reg <= to_pos(qz_reg);
            py4_reg <= py3_reg;
            nx4_reg <= nx3_reg;
            ny4_reg <= ny3_reg;
            nz4_reg <= nz3_reg;
        end
    end

    always_comb
    begin
        case (beat_reg)
            3'd0:    idx_sel = cur_reg;
            3'd1:    idx_sel = nxt_reg;
            3'd2:    idx_sel = cur_reg + 1'b1;
            3'd3:    idx_sel = cur_reg + 1'b1;
            3'd4:    idx_sel = nxt_reg;
            3'd5:    idx_sel = nxt_reg + 1'b1;
            default: idx_sel = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (out_ready && last_reg)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg  <= meta_reg[PIPE_LAST].cur;
            nxt_reg  <= meta_reg[PIPE_LAST].nxt;
            beat_reg <= '0;
            vidx_reg <= '0;
            if (meta_reg[PIPE_LAST].reject)
            begin
                kind_reg   <= KIND_REJECT;
                pos_x_reg  <= '0;
                pos_y_reg  <= '0;
                pos_z_reg  <= '0;
                norm_x_reg <= '0;
                norm_y_reg <= '0;
                norm_z_reg <= '0;
                tex_u_reg  <= '0;
                tex_v_reg  <= '0;
                last_reg   <= 1'b1;
            end
            else
            begin
                kind_reg   <= KIND_VERTEX;
                pos_x_reg  <= px4_reg;
                pos_y_reg  <= py4_reg;
                pos_z_reg  <= pz4_reg;
                norm_x_reg <= nx4_reg;
                norm_y_reg <= ny4_reg;
                norm_z_reg <= nz4_reg;
                tex_u_reg  <= meta_reg[PIPE_LAST].tex_u;
                tex_v_reg  <= meta_reg[PIPE_LAST].tex_v;
                last_reg   <= meta_reg[PIPE_LAST].edge_pt;
            end
        end
        else if (step)
        begin
            kind_reg   <= KIND_INDEX;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            norm_x_reg <= '0;
            norm_y_reg <= '0;
            norm_z_reg <= '0;
            tex_u_reg  <= '0;
            tex_v_reg  <= '0;
            vidx_reg   <= idx_sel;
            last_reg   <= (beat_reg == 3'd5);
            beat_reg   <= beat_reg + 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;
    assign norm_x       = norm_x_reg;
    assign norm_y       = norm_y_reg;
    assign norm_z       = norm_z_reg;
    assign tex_u        = tex_u_reg;
    assign tex_v        = tex_v_reg;
    assign vertex_index = vidx_reg;
    assign last         = last_reg;

    a_index_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (out_valid_reg && kind_reg == KIND_INDEX))
        else $error("index beat did not follow a non-final beat");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_INDEX) |-> (last_reg == (beat_reg == 3'd6)))
        else $error("final flag out of step with index count");

    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_REJECT) |-> last_reg)
        else $error("rejected beat not final");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[PIPE_LAST] && !adv) |=> v_reg[PIPE_LAST])
        else $error("pipeline head lost while stalled");

endmodule

// File: design/uv_sphere_tessellator_core.sv
// top level of the uv sphere tessellator
// throughput: one result beat per cycle while out_ready is high; an interior point gives 7 beats,
//   an edge point or a rejected input 1 beat, all sharing the single result port
// reset: radius 1.0 (Q8.8) and 16 segments, queue and pipeline empty
module uv_sphere_tessellator_core import uvst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_en,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SEG_W-1:0]         ring,
    input  logic [SEG_W-1:0]         sector,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               kind,
    output logic signed [POS_W-1:0]  pos_x,
    output logic signed [POS_W-1:0]  pos_y,
    output logic signed [POS_W-1:0]  pos_z,
    output logic signed [NORM_W-1:0] norm_x,
    output logic signed [NORM_W-1:0] norm_y,
    output logic signed [NORM_W-1:0] norm_z,
    output logic [TEX_W-1:0]         tex_u,
    output logic [TEX_W-1:0]         tex_v,
    output logic [IDX_W-1:0]         vertex_index,
    output logic                     last
);

    logic  q_full;
    logic  q_push;
    item_t q_wdata;
    logic  q_pop;
    item_t q_rdata;
    logic  q_valid;

    uvst_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ring         (ring),
        .sector       (sector),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    uvst_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .valid     (q_valid)
    );

    uvst_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .norm_z       (norm_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .vertex_index (vertex_index),
        .last         (last)
    );

endmodule
